/* rtl/core/alternating_drop_mode_filter_macros.svh */
// assertion macros for the alternating drop mode filter
// used by the top level; no other dependencies
`ifndef ALTERNATING_DROP_MODE_FILTER_MACROS_SVH
`define ALTERNATING_DROP_MODE_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define ADM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ADM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ADM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ADM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/adm_pkg.sv */
// shared types and constants for the alternating drop mode filter
// no dependencies
`default_nettype none
package adm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RIDX_W   = 3;

    localparam logic             REG_RETURN_INDEX = 1'b0;
    localparam logic [RIDX_W-1:0] RIDX_RESET      = 3'd2;

    typedef struct packed {
        logic en;
        logic from_top;
        logic at_end;
    } t_cell_ctrl;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       gt;
        logic                       lt;
    } t_link;

endpackage
`default_nettype wire

/* rtl/core/adm_sample_if.sv */
// input sample channel with valid/ready handshake
// depends on adm_pkg
`default_nettype none
interface adm_sample_if import adm_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface
`default_nettype wire

/* rtl/core/adm_result_if.sv */
// result channel with valid/ready handshake
// depends on adm_pkg
`default_nettype none
interface adm_result_if import adm_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered_value;

    modport source (output valid, output filtered_value, input ready);
    modport sink   (input valid, input filtered_value, output ready);
endinterface
`default_nettype wire

/* rtl/core/adm_cell.sv */
// one compare-and-shift cell of the sorted window row
// depends on adm_pkg
`default_nettype none
module adm_cell import adm_pkg::*; (
    input  wire logic                       i_clk,
    input  wire t_cell_ctrl                 i_ctrl,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire t_link                      i_lower,
    input  wire t_link                      i_upper,
    output t_link                           o_link,
    output logic signed [SAMPLE_W-1:0]      o_next
);

    logic signed [SAMPLE_W-1:0] r_value;
    logic signed [SAMPLE_W-1:0] n_value;
    logic                       own_gt;
    logic                       own_lt;
    logic                       take;
    logic                       shift;

    assign own_gt = r_value > i_sample;
    assign own_lt = r_value < i_sample;

    always_comb begin
        take  = i_ctrl.at_end || (i_ctrl.from_top ? own_gt : own_lt);
        shift = i_ctrl.from_top ? i_lower.gt : i_upper.lt;
        if (!i_ctrl.en || !take) begin
            n_value = r_value;
        end else if (shift) begin
            n_value = i_ctrl.from_top ? i_lower.value : i_upper.value;
        end else begin
            n_value = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link = '{value: r_value, gt: own_gt, lt: own_lt};
    assign o_next = n_value;

endmodule
`default_nettype wire

/* rtl/core/alternating_drop_mode_filter.sv */
// alternating drop mode filter: top level with cell row, control and config port
// depends on adm_pkg, adm_sample_if, adm_result_if, adm_cell and the macros header
//
// Each sample transfer is inserted into a sorted window of WINDOW_SIZE entries
// held in a row of compare-and-shift cells; the whole insert happens in the
// cycle of the transfer, so one sample is taken every cycle and its result is
// presented from an output register in the following cycle. A waiting result does not
// block the next sample unless the result side is stalled. While the window
// fills the middle entry is returned, afterwards the entry at return_index
// (register 0, byte address 0, reset value 2, saturated to the top entry).
`default_nettype none
`include "alternating_drop_mode_filter_macros.svh"
module alternating_drop_mode_filter import adm_pkg::*; #(
    parameter int WINDOW_SIZE = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    adm_sample_if.sink       i_sample,
    adm_result_if.source     o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int IDX_W = $clog2(WINDOW_SIZE);
    localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_drop_high;
    logic [RIDX_W-1:0]          r_return_index;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_filtered;

    logic                       accept;
    logic                       full_now;
    logic                       from_top;
    logic                       cfg_write;
    logic [IDX_W-1:0]           sel;
    logic [CMP_W-1:0]           ridx_ext;

    t_cell_ctrl                 ctrl   [WINDOW_SIZE];
    t_link                      links  [WINDOW_SIZE];
    logic signed [SAMPLE_W-1:0] nexts  [WINDOW_SIZE];

    localparam t_link EDGE_LINK = '{value: '0, gt: 1'b0, lt: 1'b0};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_RETURN_INDEX);
    assign prdata    = (paddr[2] == REG_RETURN_INDEX) ?
                       {{(32-RIDX_W){1'b0}}, r_return_index} : 32'd0;

    assign i_sample.ready = !r_out_valid || o_result.ready;
    assign accept         = i_sample.valid && i_sample.ready;

    assign full_now = (r_count == CNT_W'(WINDOW_SIZE));
    assign from_top = !full_now || r_drop_high;
    assign n_count  = full_now ? r_count : r_count + CNT_W'(1);
    assign ridx_ext = CMP_W'(r_return_index);

    always_comb begin
        if (n_count < CNT_W'(WINDOW_SIZE)) begin
            sel = IDX_W'(n_count >> 1);
        end else if (ridx_ext >= CMP_W'(WINDOW_SIZE)) begin
            sel = IDX_W'(WINDOW_SIZE - 1);
        end else begin
            sel = IDX_W'(r_return_index);
        end
    end

    genvar k;
    generate
        for (k = 0; k < WINDOW_SIZE; k++) begin : g_cell
            t_link lower;
            t_link upper;

            if (k == 0) begin : g_lo_edge
                assign lower = EDGE_LINK;
            end else begin : g_lo
                assign lower = links[k-1];
            end
            if (k == WINDOW_SIZE - 1) begin : g_hi_edge
                assign upper = EDGE_LINK;
            end else begin : g_hi
                assign upper = links[k+1];
            end

            assign ctrl[k].en       = accept && (CNT_W'(k) < n_count);
            assign ctrl[k].from_top = from_top;
            assign ctrl[k].at_end   = from_top ? (CNT_W'(k + 1) == n_count) : (k == 0);

            adm_cell u_cell (
                .i_clk    (i_clk),
                .i_ctrl   (ctrl[k]),
                .i_sample (i_sample.sample_value),
                .i_lower  (lower),
                .i_upper  (upper),
                .o_link   (links[k]),
                .o_next   (nexts[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_drop_high    <= 1'b1;
            r_return_index <= RIDX_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_return_index <= pwdata[RIDX_W-1:0];
            end
            if (accept) begin
                r_count     <= n_count;
                r_drop_high <= full_now ? !r_drop_high : 1'b0;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_filtered <= nexts[sel];
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.filtered_value = r_filtered;

    `ADM_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(WINDOW_SIZE))
    `ADM_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, accept && !full_now, r_count == $past(r_count) + CNT_W'(1))
    `ADM_ASSERT_NEXT(a_fill_clears_drop, i_clk, i_rst_n, accept && !full_now, !r_drop_high)
    `ADM_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, accept, o_result.valid)

endmodule
`default_nettype wire
